/* src/trang_pkg.sv */
// ----------------------------------------------------------------------------
// trang_pkg
// Shared types and constants for the triangulation angle pipeline.
// ----------------------------------------------------------------------------
package trang_pkg;

    localparam int NUM_REGS     = 6;
    localparam int CORDIC_STEPS = 25;
    localparam int ROOT_BITS    = 32;

    localparam logic [2:0] REG_C1_X = 3'd0;
    localparam logic [2:0] REG_C1_Y = 3'd1;
    localparam logic [2:0] REG_C1_Z = 3'd2;
    localparam logic [2:0] REG_C2_X = 3'd3;
    localparam logic [2:0] REG_C2_Y = 3'd4;
    localparam logic [2:0] REG_C2_Z = 3'd5;

    localparam logic [16:0] ANGLE_MAX = 17'd102944;

    localparam logic [23:0] ATAN_TAB [CORDIC_STEPS] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214,
        24'd524117, 24'd262123, 24'd131069, 24'd65536, 24'd32768,
        24'd16384, 24'd8192, 24'd4096, 24'd2048, 24'd1024, 24'd512,
        24'd256, 24'd128, 24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2,
        24'd1
    };

    typedef struct packed {
        logic        deg;
        logic [30:0] x;
        logic [63:0] rem;
        logic [31:0] root;
    } sq_lane_t;

    typedef struct packed {
        logic               deg;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [27:0] z;
    } cd_lane_t;

endpackage

/* src/trang_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// trang_sqrt_cell
// One bit of a restoring square root; a row of these forms the root.
// ----------------------------------------------------------------------------
module trang_sqrt_cell
    import trang_pkg::*;
#(
    parameter int BIT = 31
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  sq_lane_t in_lane,
    output logic     out_valid,
    output sq_lane_t out_lane
);

    logic     valid_reg;
    sq_lane_t lane_reg;
    sq_lane_t lane_next;
    logic [65:0] trial;

    always_comb begin
        trial = ({34'd0, in_lane.root} << (BIT + 1)) + (66'd1 << (2 * BIT));
        lane_next = in_lane;
        if ({2'b00, in_lane.rem} >= trial) begin
            lane_next.rem  = in_lane.rem - trial[63:0];
            lane_next.root = in_lane.root | (32'd1 << BIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

/* src/trang_cordic_cell.sv */
// ----------------------------------------------------------------------------
// trang_cordic_cell
// One vectoring CORDIC micro-rotation; a row of these forms the arctangent.
// ----------------------------------------------------------------------------
module trang_cordic_cell
    import trang_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  cd_lane_t in_lane,
    output logic     out_valid,
    output cd_lane_t out_lane
);

    logic               valid_reg;
    cd_lane_t           lane_reg;
    cd_lane_t           lane_next;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [27:0] step_ang;

    always_comb begin
        xs = in_lane.cx[33] ? -((-in_lane.cx) >>> STEP) : (in_lane.cx >>> STEP);
        ys = in_lane.cy[33] ? -((-in_lane.cy) >>> STEP) : (in_lane.cy >>> STEP);
        step_ang  = signed'({4'd0, ATAN_TAB[STEP]});
        lane_next = in_lane;
        if (in_lane.cy > 34'sd0) begin
            lane_next.cx = in_lane.cx + ys;
            lane_next.cy = in_lane.cy - xs;
            lane_next.z  = in_lane.z + step_ang;
        end else if (in_lane.cy < 34'sd0) begin
            lane_next.cx = in_lane.cx - ys;
            lane_next.cy = in_lane.cy + xs;
            lane_next.z  = in_lane.z - step_ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

/* src/triangulation_angle.sv */
// ----------------------------------------------------------------------------
// triangulation_angle
// Smaller angle between the two viewing rays of a point, via cross and dot
// products, a bit-per-cell square root and a cell-per-step CORDIC.
// ----------------------------------------------------------------------------
// The block takes one point per clock unless held and returns its angle
// through nine front-end stages, 32 square-root cells, two normalizing
// stages, 25 CORDIC cells and the output register. A two-entry output
// buffer lets one more point enter while a result waits; the whole pipeline
// holds while the second entry is full. The user must write camera centers
// via the cfg port only while no point is in flight; the block does not check.
module triangulation_angle
    import trang_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // point_x, point_y, point_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // ray_angle, zero pad
    output logic        m_tuser    // degenerate
);

    logic signed [31:0] ctr_reg [NUM_REGS];

    logic en;
    logic skid_valid_reg;
    logic [16:0] skid_angle_reg;
    logic skid_deg_reg;
    logic out_valid_reg;
    logic [16:0] out_angle_reg;
    logic out_deg_reg;

    logic [7:0] v_reg;
    logic [7:0] deg_reg;

    logic signed [32:0] ra_reg [3];
    logic signed [32:0] rb_reg [3];
    logic signed [30:0] na_reg [3];
    logic signed [30:0] nb_reg [3];
    logic signed [61:0] prod_reg [3][3];
    logic signed [61:0] cr_reg [3];
    logic signed [62:0] dot_reg;
    logic [60:0] uc_reg [3];
    logic [61:0] ud_reg;
    logic [61:0] or_reg;
    logic [60:0] uc6_reg [3];
    logic [61:0] ud6_reg;
    logic [4:0]  sh_reg;
    logic [30:0] tc_reg [3];
    logic [30:0] x7_reg;
    logic [61:0] sq_reg [3];
    logic [30:0] x8_reg;

    logic     sq_valid [ROOT_BITS+1];
    sq_lane_t sq_lane  [ROOT_BITS+1];
    logic     cd_valid [CORDIC_STEPS+1];
    cd_lane_t cd_lane  [CORDIC_STEPS+1];

    logic        n_valid_reg;
    logic        n_deg_reg;
    logic [30:0] n_x_reg;
    logic [31:0] n_y_reg;
    logic        n_right_reg;
    logic [4:0]  n_left_reg;
    logic        c_valid_reg;
    cd_lane_t    c_lane_reg;

    logic signed [32:0] ra_next [3];
    logic signed [32:0] rb_next [3];
    logic signed [30:0] na_next [3];
    logic signed [30:0] nb_next [3];
    logic [32:0] ma [3];
    logic [32:0] mb [3];
    logic [32:0] ora;
    logic [32:0] orb;
    logic [1:0]  sa;
    logic [1:0]  sb;
    logic [4:0]  sh_next;
    logic [31:0] nm;
    logic [4:0]  npos;
    logic [31:0] xn;
    logic [31:0] yn;
    logic [27:0] zc;
    logic [19:0] q;
    logic [16:0] angle;

    assign en = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                ctr_reg[k] <= 32'sd0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_C1_X: ctr_reg[0] <= cfg_wdata;
                REG_C1_Y: ctr_reg[1] <= cfg_wdata;
                REG_C1_Z: ctr_reg[2] <= cfg_wdata;
                REG_C2_X: ctr_reg[3] <= cfg_wdata;
                REG_C2_Y: ctr_reg[4] <= cfg_wdata;
                REG_C2_Z: ctr_reg[5] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ra_next[k] = 33'(signed'(s_tdata[32*k +: 32])) - 33'(ctr_reg[k]);
            rb_next[k] = 33'(signed'(s_tdata[32*k +: 32])) - 33'(ctr_reg[3+k]);
        end
    end

    always_comb begin
        ora = '0;
        orb = '0;
        for (int k = 0; k < 3; k++) begin
            ma[k] = ra_reg[k][32] ? 33'(-ra_reg[k]) : 33'(ra_reg[k]);
            mb[k] = rb_reg[k][32] ? 33'(-rb_reg[k]) : 33'(rb_reg[k]);
            ora = ora | ma[k];
            orb = orb | mb[k];
        end
        sa = ora[32] ? 2'd3 : ora[31] ? 2'd2 : ora[30] ? 2'd1 : 2'd0;
        sb = orb[32] ? 2'd3 : orb[31] ? 2'd2 : orb[30] ? 2'd1 : 2'd0;
        for (int k = 0; k < 3; k++) begin
            na_next[k] = ra_reg[k][32] ? -signed'(31'(ma[k] >> sa))
                                       : signed'(31'(ma[k] >> sa));
            nb_next[k] = rb_reg[k][32] ? -signed'(31'(mb[k] >> sb))
                                       : signed'(31'(mb[k] >> sb));
        end
    end

    always_comb begin
        sh_next = 5'd0;
        for (int i = 31; i < 62; i++) begin
            if (or_reg[i]) begin
                sh_next = 5'(i - 30);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[6:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            deg_reg[0] <= (ra_next[0] == 0 && ra_next[1] == 0 && ra_next[2] == 0) ||
                          (rb_next[0] == 0 && rb_next[1] == 0 && rb_next[2] == 0);
            deg_reg[7:1] <= deg_reg[6:0];
            for (int k = 0; k < 3; k++) begin
                ra_reg[k] <= ra_next[k];
                rb_reg[k] <= rb_next[k];
                na_reg[k] <= na_next[k];
                nb_reg[k] <= nb_next[k];
                for (int j = 0; j < 3; j++) begin
                    prod_reg[k][j] <= 62'(na_reg[k]) * 62'(nb_reg[j]);
                end
            end
            cr_reg[0] <= prod_reg[1][2] - prod_reg[2][1];
            cr_reg[1] <= prod_reg[2][0] - prod_reg[0][2];
            cr_reg[2] <= prod_reg[0][1] - prod_reg[1][0];
            dot_reg   <= 63'(prod_reg[0][0]) + 63'(prod_reg[1][1]) + 63'(prod_reg[2][2]);
            for (int k = 0; k < 3; k++) begin
                uc_reg[k] <= cr_reg[k][61] ? 61'(-cr_reg[k]) : 61'(cr_reg[k]);
            end
            ud_reg <= dot_reg[62] ? 62'(-dot_reg) : 62'(dot_reg);
            or_reg <= (dot_reg[62] ? 62'(-dot_reg) : 62'(dot_reg))
                    | {1'b0, cr_reg[0][61] ? 61'(-cr_reg[0]) : 61'(cr_reg[0])}
                    | {1'b0, cr_reg[1][61] ? 61'(-cr_reg[1]) : 61'(cr_reg[1])}
                    | {1'b0, cr_reg[2][61] ? 61'(-cr_reg[2]) : 61'(cr_reg[2])};
            for (int k = 0; k < 3; k++) begin
                uc6_reg[k] <= uc_reg[k];
                tc_reg[k]  <= 31'(uc6_reg[k] >> sh_reg);
                sq_reg[k]  <= {31'd0, tc_reg[k]} * {31'd0, tc_reg[k]};
            end
            ud6_reg <= ud_reg;
            sh_reg  <= sh_next;
            x7_reg  <= 31'(ud6_reg >> sh_reg);
            x8_reg  <= x7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid[0] <= 1'b0;
        end else if (en) begin
            sq_valid[0] <= v_reg[7];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_lane[0].deg  <= deg_reg[7];
            sq_lane[0].x    <= x8_reg;
            sq_lane[0].rem  <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
            sq_lane[0].root <= '0;
        end
    end

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
        trang_sqrt_cell #(.BIT(ROOT_BITS - 1 - g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_valid[g]),
            .in_lane   (sq_lane[g]),
            .out_valid (sq_valid[g+1]),
            .out_lane  (sq_lane[g+1])
        );
    end

    always_comb begin
        nm   = {1'b0, sq_lane[ROOT_BITS].x} | sq_lane[ROOT_BITS].root;
        npos = 5'd0;
        for (int i = 0; i < 31; i++) begin
            if (nm[i]) begin
                npos = 5'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            n_valid_reg <= sq_valid[ROOT_BITS];
            c_valid_reg <= n_valid_reg;
        end
    end

    always_comb begin
        if (n_right_reg) begin
            xn = {1'b0, n_x_reg} >> 1;
            yn = n_y_reg >> 1;
        end else begin
            xn = {1'b0, n_x_reg} << n_left_reg;
            yn = n_y_reg << n_left_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_deg_reg   <= sq_lane[ROOT_BITS].deg;
            n_x_reg     <= sq_lane[ROOT_BITS].x;
            n_y_reg     <= sq_lane[ROOT_BITS].root;
            n_right_reg <= nm[31];
            n_left_reg  <= 5'd30 - npos;
            c_lane_reg.deg <= n_deg_reg;
            c_lane_reg.cx  <= signed'({2'b00, xn});
            c_lane_reg.cy  <= signed'({2'b00, yn});
            c_lane_reg.z   <= '0;
        end
    end

    assign cd_valid[0] = c_valid_reg;
    assign cd_lane[0]  = c_lane_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        trang_cordic_cell #(.STEP(g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cd_valid[g]),
            .in_lane   (cd_lane[g]),
            .out_valid (cd_valid[g+1]),
            .out_lane  (cd_lane[g+1])
        );
    end

    always_comb begin
        zc = cd_lane[CORDIC_STEPS].z[27] ? 28'd0 : 28'(cd_lane[CORDIC_STEPS].z);
        q  = 20'((zc + 28'd128) >> 8);
        if (cd_lane[CORDIC_STEPS].deg) begin
            angle = '0;
        end else if (q > {3'd0, ANGLE_MAX}) begin
            angle = ANGLE_MAX;
        end else begin
            angle = q[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= cd_valid[CORDIC_STEPS];
        end else if (cd_valid[CORDIC_STEPS]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_angle_reg <= skid_angle_reg;
                out_deg_reg   <= skid_deg_reg;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_angle_reg <= angle;
            out_deg_reg   <= cd_lane[CORDIC_STEPS].deg;
        end else begin
            skid_angle_reg <= angle;
            skid_deg_reg   <= cd_lane[CORDIC_STEPS].deg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_angle_reg};
    assign m_tuser  = out_deg_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output request");

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_deg_reg |-> out_angle_reg == 17'd0)
        else $error("degenerate request with nonzero angle");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_angle_reg <= ANGLE_MAX)
        else $error("angle beyond pi/2");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_tready |=> $stable(cd_valid[CORDIC_STEPS]) && skid_valid_reg)
        else $error("pipeline advanced while stalled");
`endif

endmodule
